// ===== hdl/rotp_pkg.sv =====
// rotp_pkg: types and constants shared by the relocatable object token parser
// depends on: nothing
`timescale 1ns / 1ps

package rotp_pkg;

  localparam int unsigned LOC_W = 17;
  localparam logic [LOC_W-1:0] IMAGE_LIMIT = 17'h10000;

  // token bytes
  localparam logic [7:0] TOK_ABS       = 8'h00;
  localparam logic [7:0] TOK_PROG      = 8'h01;
  localparam logic [7:0] TOK_DATA      = 8'h02;
  localparam logic [7:0] TOK_COMMON    = 8'h03;
  localparam logic [7:0] TOK_LINK_ITEM = 8'h80;
  localparam logic [7:0] TOK_PAD       = 8'hFE;

  // control codes
  localparam logic [7:0] CTRL_MAX       = 8'd15;
  localparam logic [7:0] CTRL_ATYPE_MIN = 8'd5;
  localparam logic [7:0] CTRL_ATYPE_MAX = 8'd14;
  localparam logic [7:0] CTRL_NAME_MAX  = 8'd8;
  localparam logic [3:0] CTRL_SET_LOC   = 4'd11;
  localparam logic [3:0] CTRL_END_MOD   = 4'd14;
  localparam logic [3:0] CTRL_END_FILE  = 4'd15;
  localparam logic [3:0] CTRL_NAME_LAST = 4'd8;
  localparam logic [7:0] ATYPE_PROG     = 8'd1;

  // result kinds
  localparam logic [2:0] KIND_ABS      = 3'd0;
  localparam logic [2:0] KIND_WORD     = 3'd1;
  localparam logic [2:0] KIND_SPECIAL  = 3'd2;
  localparam logic [2:0] KIND_END_MOD  = 3'd3;
  localparam logic [2:0] KIND_END_FILE = 3'd4;
  localparam logic [2:0] KIND_BAD_TOK  = 3'd5;
  localparam logic [2:0] KIND_BAD_CTRL = 3'd6;

  typedef enum logic [3:0] {
    PH_TOKEN = 4'd0,
    PH_ABS   = 4'd1,
    PH_WLO   = 4'd2,
    PH_WHI   = 4'd3,
    PH_PAD1  = 4'd4,
    PH_PAD2  = 4'd5,
    PH_CTRL  = 4'd6,
    PH_ATYPE = 4'd7,
    PH_VLO   = 4'd8,
    PH_VHI   = 4'd9,
    PH_NLEN  = 4'd10,
    PH_NAME  = 4'd11
  } phase_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] address;
    logic [15:0] value;
    logic [1:0]  reloc_class;
    logic [3:0]  control;
    logic [7:0]  addr_type;
    logic [7:0]  name_length;
    logic [7:0]  module_index;
    logic        overflow;
  } rotp_result_t;

endpackage

// ===== hdl/relocatable_object_token_parser_core.sv =====
// relocatable_object_token_parser_core: input register, parser and result register
// depends on: rotp_pkg, rotp_parser
//
//   channel   direction  handshake               payload
//   in_       in         in_valid / in_ready     in_stream_byte
//   out_      out        out_valid / out_ready   kind, address, value, reloc_class,
//                                                control, addr_type, name_length,
//                                                module_index, overflow
//
// one byte per cycle sustained while out_ is not stalled; a taken byte goes into
// the input register, and its result goes from there into the result register
// rst_n is synchronous: parser state, module count and both valid flags clear
// a byte that gives no result moves on even while a result waits downstream
// a byte that gives a result waits in the input register until the result
// register frees up; after end file or a bad byte every request is dropped
`timescale 1ns / 1ps

module relocatable_object_token_parser_core import rotp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_stream_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [15:0] out_address,
  output logic [15:0] out_value,
  output logic [1:0]  out_reloc_class,
  output logic [3:0]  out_control,
  output logic [7:0]  out_addr_type,
  output logic [7:0]  out_name_length,
  output logic [7:0]  out_module_index,
  output logic        out_overflow
);

  logic         in_valid_r, in_valid_nxt;
  logic [7:0]   in_byte_r, in_byte_nxt;
  logic         out_valid_r, out_valid_nxt;
  rotp_result_t out_r, out_nxt;
  rotp_result_t res;
  logic         emit, out_free, step;

  assign out_free = !out_valid_r || out_ready;
  assign step     = in_valid_r && (!emit || out_free);
  assign in_ready = !in_valid_r || step;

  rotp_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .stream_byte (in_byte_r),
    .emit        (emit),
    .result      (res)
  );

  always_comb begin
    in_valid_nxt = in_valid_r;
    in_byte_nxt  = in_byte_r;
    if (in_valid && in_ready) begin
      in_valid_nxt = 1'b1;
      in_byte_nxt  = in_stream_byte;
    end else if (step) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (step && emit) begin
      out_valid_nxt = 1'b1;
      out_nxt       = res;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_byte_r <= in_byte_nxt;
    out_r     <= out_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_r.kind;
  assign out_address      = out_r.address;
  assign out_value        = out_r.value;
  assign out_reloc_class  = out_r.reloc_class;
  assign out_control      = out_r.control;
  assign out_addr_type    = out_r.addr_type;
  assign out_name_length  = out_r.name_length;
  assign out_module_index = out_r.module_index;
  assign out_overflow     = out_r.overflow;

`ifndef SYNTH
  a_ovf_code_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_overflow) |-> (out_kind == KIND_ABS || out_kind == KIND_WORD))
    else $error("overflow on a non-code result");

  a_class_word_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_reloc_class != 2'd0) |-> (out_kind == KIND_WORD))
    else $error("relocation class on a non-word result");

  a_silent_after_stop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && (out_kind == KIND_END_FILE ||
     out_kind == KIND_BAD_TOK || out_kind == KIND_BAD_CTRL)) |=> !out_valid)
    else $error("result after end of stream");

  a_stall_holds_byte: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (in_valid_r && emit && out_valid_r && !out_ready))
    else $error("input stalled without a blocked result");
`endif

endmodule

// ===== hdl/rotp_parser.sv =====
// rotp_parser: token state machine, location counter and result decode
// depends on: rotp_pkg
`timescale 1ns / 1ps

module rotp_parser import rotp_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         step,
  input  logic [7:0]   stream_byte,
  output logic         emit,
  output rotp_result_t result
);

  phase_t            phase_r, phase_nxt;
  logic [1:0]        token_class_r, token_class_nxt;
  logic [7:0]        low_byte_r, low_byte_nxt;
  logic [3:0]        control_code_r, control_code_nxt;
  logic [7:0]        address_type_r, address_type_nxt;
  logic [15:0]       item_value_r, item_value_nxt;
  logic [7:0]        name_total_r, name_total_nxt;
  logic [7:0]        name_left_r, name_left_nxt;
  logic [LOC_W-1:0]  loc_r, loc_nxt;
  logic [7:0]        module_count_r, module_count_nxt;
  logic              stopped_r, stopped_nxt;

  logic [LOC_W-1:0]  sum1, sum2;
  logic              ovf1, ovf2, fin;
  logic [7:0]        left_dec;

  assign sum1     = loc_r + LOC_W'(1);
  assign sum2     = loc_r + LOC_W'(2);
  assign ovf1     = (sum1 > IMAGE_LIMIT);
  assign ovf2     = (sum2 > IMAGE_LIMIT);
  assign left_dec = name_left_r - 8'd1;

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (!stopped_r) begin
      case (phase_r)
        PH_TOKEN: begin
          if (stream_byte == TOK_ABS) begin
            phase_nxt = PH_ABS;
          end else if (stream_byte == TOK_PROG || stream_byte == TOK_DATA ||
                       stream_byte == TOK_COMMON) begin
            phase_nxt = PH_WLO;
          end else if (stream_byte == TOK_PAD) begin
            phase_nxt = PH_PAD1;
          end else if (stream_byte == TOK_LINK_ITEM) begin
            phase_nxt = PH_CTRL;
          end
        end
        PH_ABS:  phase_nxt = PH_TOKEN;
        PH_WLO:  phase_nxt = PH_WHI;
        PH_WHI:  phase_nxt = PH_TOKEN;
        PH_PAD1: phase_nxt = PH_PAD2;
        PH_PAD2: phase_nxt = PH_TOKEN;
        PH_CTRL: begin
          if (stream_byte > CTRL_MAX) begin
            phase_nxt = PH_TOKEN;
          end else if (stream_byte >= CTRL_ATYPE_MIN && stream_byte <= CTRL_ATYPE_MAX) begin
            phase_nxt = PH_ATYPE;
          end else if (stream_byte <= CTRL_NAME_MAX) begin
            phase_nxt = PH_NLEN;
          end else begin
            phase_nxt = PH_TOKEN;
          end
        end
        PH_ATYPE: phase_nxt = PH_VLO;
        PH_VLO:   phase_nxt = PH_VHI;
        PH_VHI: begin
          if (control_code_r <= CTRL_NAME_LAST) begin
            phase_nxt = PH_NLEN;
          end else begin
            phase_nxt = PH_TOKEN;
          end
        end
        PH_NLEN: begin
          if (stream_byte == 8'd0) begin
            phase_nxt = PH_TOKEN;
          end else begin
            phase_nxt = PH_NAME;
          end
        end
        PH_NAME: begin
          if (left_dec == 8'd0) begin
            phase_nxt = PH_TOKEN;
          end
        end
        default: phase_nxt = PH_TOKEN;
      endcase
    end
  end

  // datapath and result
  always_comb begin
    token_class_nxt  = token_class_r;
    low_byte_nxt     = low_byte_r;
    control_code_nxt = control_code_r;
    address_type_nxt = address_type_r;
    item_value_nxt   = item_value_r;
    name_total_nxt   = name_total_r;
    name_left_nxt    = name_left_r;
    loc_nxt          = loc_r;
    module_count_nxt = module_count_r;
    stopped_nxt      = stopped_r;
    fin              = 1'b0;
    emit             = 1'b0;
    result              = '0;
    result.address      = loc_r[15:0];
    result.module_index = module_count_r;
    if (!stopped_r) begin
      case (phase_r)
        PH_TOKEN: begin
          if (stream_byte == TOK_PROG || stream_byte == TOK_DATA ||
              stream_byte == TOK_COMMON) begin
            token_class_nxt = stream_byte[1:0];
          end else if (stream_byte != TOK_ABS && stream_byte != TOK_PAD &&
                       stream_byte != TOK_LINK_ITEM) begin
            stopped_nxt  = 1'b1;
            emit         = 1'b1;
            result.kind  = KIND_BAD_TOK;
            result.value = {8'h00, stream_byte};
          end
        end
        PH_ABS: begin
          loc_nxt         = ovf1 ? IMAGE_LIMIT : sum1;
          emit            = 1'b1;
          result.kind     = KIND_ABS;
          result.value    = {8'h00, stream_byte};
          result.overflow = ovf1;
        end
        PH_WLO: low_byte_nxt = stream_byte;
        PH_WHI: begin
          loc_nxt            = ovf2 ? IMAGE_LIMIT : sum2;
          emit               = 1'b1;
          result.kind        = KIND_WORD;
          result.value       = {stream_byte, low_byte_r};
          result.reloc_class = token_class_r;
          result.overflow    = ovf2;
        end
        PH_CTRL: begin
          if (stream_byte > CTRL_MAX) begin
            stopped_nxt  = 1'b1;
            emit         = 1'b1;
            result.kind  = KIND_BAD_CTRL;
            result.value = {8'h00, stream_byte};
          end else begin
            control_code_nxt = stream_byte[3:0];
            address_type_nxt = '0;
            item_value_nxt   = '0;
            name_total_nxt   = '0;
            name_left_nxt    = '0;
            fin = !(stream_byte >= CTRL_ATYPE_MIN && stream_byte <= CTRL_ATYPE_MAX) &&
                  !(stream_byte <= CTRL_NAME_MAX);
          end
        end
        PH_ATYPE: address_type_nxt = stream_byte;
        PH_VLO:   item_value_nxt = {8'h00, stream_byte};
        PH_VHI: begin
          item_value_nxt = {stream_byte, item_value_r[7:0]};
          fin = (control_code_r > CTRL_NAME_LAST);
        end
        PH_NLEN: begin
          name_total_nxt = stream_byte;
          name_left_nxt  = stream_byte;
          fin = (stream_byte == 8'd0);
        end
        PH_NAME: begin
          name_left_nxt = left_dec;
          fin = (left_dec == 8'd0);
        end
        default: fin = 1'b0;
      endcase
      if (fin) begin
        result.kind = KIND_SPECIAL;
        if (control_code_nxt == CTRL_SET_LOC && address_type_nxt == ATYPE_PROG) begin
          loc_nxt = '0;
        end
        if (control_code_nxt == CTRL_END_MOD) begin
          loc_nxt          = '0;
          module_count_nxt = module_count_r + 8'd1;
          result.kind      = KIND_END_MOD;
        end
        if (control_code_nxt == CTRL_END_FILE) begin
          stopped_nxt = 1'b1;
          result.kind = KIND_END_FILE;
        end
        emit                = 1'b1;
        result.address      = loc_nxt[15:0];
        result.value        = item_value_nxt;
        result.control      = control_code_nxt;
        result.addr_type    = address_type_nxt;
        result.name_length  = name_total_nxt;
        result.module_index = module_count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_TOKEN;
      token_class_r  <= '0;
      low_byte_r     <= '0;
      control_code_r <= '0;
      address_type_r <= '0;
      item_value_r   <= '0;
      name_total_r   <= '0;
      name_left_r    <= '0;
      loc_r          <= '0;
      module_count_r <= '0;
      stopped_r      <= 1'b0;
    end else if (step) begin
      phase_r        <= phase_nxt;
      token_class_r  <= token_class_nxt;
      low_byte_r     <= low_byte_nxt;
      control_code_r <= control_code_nxt;
      address_type_r <= address_type_nxt;
      item_value_r   <= item_value_nxt;
      name_total_r   <= name_total_nxt;
      name_left_r    <= name_left_nxt;
      loc_r          <= loc_nxt;
      module_count_r <= module_count_nxt;
      stopped_r      <= stopped_nxt;
    end
  end

endmodule
